// ===== sv/plane_wave_field_eval_macros.svh =====
// Assertion macros for the checker file pwf_checker.sv.
`ifndef PLANE_WAVE_FIELD_EVAL_MACROS_SVH
`define PLANE_WAVE_FIELD_EVAL_MACROS_SVH

// Same-cycle implication, off while reset is held
`define PWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwf: check failed");

// Next-cycle implication, off while reset is held
`define PWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwf: check failed");

`endif

// ===== sv/pwf_pkg.sv =====
`default_nettype none
package pwf_pkg;

  localparam int WORD_W           = 32;
  localparam int FREQ_W           = 31;
  localparam int IDX_W            = 3;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 32;

  // floored Q.16 product, phase sum, cross component
  localparam int PROD_W  = 48;
  localparam int SUM_W   = 50;
  localparam int CROSS_W = 49;
  // CORDIC datapath and reduced phase
  localparam int CW      = 34;
  localparam int PH_W    = 19;
  localparam int ANG_W   = 20;

  localparam int TWO_PI_Q16  = 411775;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int GAIN_Q30    = 652032874;

  // register indexes
  localparam logic [IDX_W-1:0] REG_K_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_K_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_K_Z   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FREQ  = 3'd3;
  localparam logic [IDX_W-1:0] REG_AMP_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_AMP_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_AMP_Z = 3'd6;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd843314856;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043836;
      5'd3:  r = 32'd133525158;
      5'd4:  r = 32'd67021686;
      5'd5:  r = 32'd33543515;
      5'd6:  r = 32'd16775850;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194282;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      5'd24: r = 32'd63;
      5'd25: r = 32'd31;
      5'd26: r = 32'd15;
      5'd27: r = 32'd7;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pwf_phase.sv =====
`default_nettype none
module pwf_phase (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_v,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  pos_x,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  pos_y,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  pos_z,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  t_now,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  k_x,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  k_y,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  k_z,
  input  wire logic        [pwf_pkg::FREQ_W-1:0]  freq,
  output logic                                    out_v,
  output logic             [pwf_pkg::PH_W-1:0]    phase
);
  import pwf_pkg::*;

  localparam int STAGES = 6;
  localparam int HALF_W = SUM_W / 2;
  localparam int RCP_W  = 32;
  localparam int PP_W   = HALF_W + RCP_W;
  localparam int LO_W   = PH_W + 2;

  localparam logic [SUM_W-1:0] OFF =
    SUM_W'(((64'd1 << 48) / TWO_PI_Q16 + 1) * TWO_PI_Q16);
  // floor(2^SUM_W / 2*pi): the quotient estimate is low by at most one
  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << SUM_W) / TWO_PI_Q16);
  localparam logic [LO_W-1:0]  TWO_PI_LO = LO_W'(TWO_PI_Q16);

  logic signed [2*WORD_W-1:0] mx, my, mz, mw;
  logic signed [PROD_W-1:0]   px_r, py_r, pz_r, pw_r;
  logic signed [SUM_W-1:0]    sum;
  logic        [SUM_W-1:0]    u_r;
  logic        [PP_W-1:0]     hi_prod, lo_prod;
  logic        [PP_W-1:0]     hi_r, lo_r;
  logic        [PP_W:0]       qsum;
  logic        [LO_W-1:0]     q_r, qt;
  logic        [LO_W-1:0]     ulo2_r, ulo3_r;
  logic        [LO_W-1:0]     r_r, r_sub;
  logic        [PH_W-1:0]     ph_r;
  logic        [STAGES-1:0]   v_r;

  assign mx = pos_x * k_x;
  assign my = pos_y * k_y;
  assign mz = pos_z * k_z;
  assign mw = $signed({1'b0, freq}) * t_now;

  // sum and shift by a multiple of 2*pi so the value is non-negative
  assign sum = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r) - SUM_W'(pw_r);

  // quotient estimate from the reciprocal, split into two narrow multiplies
  assign hi_prod = u_r[SUM_W-1:HALF_W] * RCP;
  assign lo_prod = u_r[HALF_W-1:0] * RCP;
  assign qsum    = {1'b0, hi_r} + (PP_W+1)'(lo_r >> HALF_W);

  // remainder only needs its low bits, as it lies below twice 2*pi
  assign qt    = q_r * TWO_PI_LO;
  assign r_sub = r_r - TWO_PI_LO;

  // advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_v};
    end
  end

  // products, offset sum, reciprocal multiply, quotient, remainder, final correction
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= PROD_W'(mx >>> 16);
      py_r   <= PROD_W'(my >>> 16);
      pz_r   <= PROD_W'(mz >>> 16);
      pw_r   <= PROD_W'(mw >>> 16);
      u_r    <= sum + OFF;
      hi_r   <= hi_prod;
      lo_r   <= lo_prod;
      ulo2_r <= u_r[LO_W-1:0];
      q_r    <= qsum[HALF_W +: LO_W];
      ulo3_r <= ulo2_r;
      r_r    <= ulo3_r - qt;
      ph_r   <= (r_r >= TWO_PI_LO) ? r_sub[PH_W-1:0] : r_r[PH_W-1:0];
    end
  end

  assign out_v = v_r[STAGES-1];
  assign phase = ph_r;

endmodule
`default_nettype wire

// ===== sv/pwf_cordic.sv =====
`default_nettype none
module pwf_cordic #(
  parameter int CORDIC_STEPS = pwf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_v,
  input  wire logic        [pwf_pkg::PH_W-1:0] phase,
  output logic                                out_v,
  output logic signed      [pwf_pkg::CW-1:0]   cos_q
);
  import pwf_pkg::*;

  logic signed [ANG_W-1:0] ang;
  logic                    fold_neg;
  logic signed [CW-1:0]    x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]    y_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]    z_r [0:CORDIC_STEPS];
  logic                    n_r [0:CORDIC_STEPS];
  logic                    v_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]    q_r;
  logic                    qv_r;

  // fold the angle into [-pi/2, pi/2], noting a sign flip
  always_comb begin
    ang      = $signed({1'b0, phase});
    fold_neg = 1'b0;
    if (ang > ANG_W'(PI_Q16)) begin
      ang = ang - ANG_W'(TWO_PI_Q16);
    end
    if (ang > ANG_W'(HALF_PI_Q16)) begin
      ang      = ang - ANG_W'(PI_Q16);
      fold_neg = 1'b1;
    end else if (ang < -ANG_W'(HALF_PI_Q16)) begin
      ang      = ang + ANG_W'(PI_Q16);
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      x_r[0] <= CW'(GAIN_Q30);
      y_r[0] <= '0;
      z_r[0] <= CW'(ang) <<< 14;
      n_r[0] <= fold_neg;
    end
  end

  // one rotation per stage, steered on the residual angle sign
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_q30(5'(i))));
    logic signed [CW-1:0] dx, dy;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        n_r[i+1] <= n_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  // apply the fold sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
    end else if (en) begin
      qv_r <= v_r[CORDIC_STEPS];
    end
    if (en) begin
      q_r <= n_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    end
  end

  assign out_v = qv_r;
  assign cos_q = q_r;

endmodule
`default_nettype wire

// ===== sv/pwf_scale.sv =====
`default_nettype none
module pwf_scale (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [pwf_pkg::CROSS_W-1:0]  val,
  input  wire logic signed [pwf_pkg::CW-1:0]       cos_q,
  output logic signed      [pwf_pkg::WORD_W-1:0]   res
);
  import pwf_pkg::*;

  localparam int VH_W = CROSS_W - 16;
  localparam int A_W  = VH_W + CW;
  localparam int BL_W = 17 + CW;
  localparam int BH_W = BL_W - 16;
  localparam int S_W  = A_W + 1;
  localparam logic signed [S_W-1:0] SAT_HI = S_W'((64'sd1 <<< (WORD_W - 1)) - 1);
  localparam logic signed [S_W-1:0] SAT_LO = -SAT_HI - 1;

  logic signed [VH_W-1:0] vh;
  logic signed [A_W-1:0]  a_prod;
  logic signed [BL_W-1:0] bl_prod;
  logic signed [A_W-1:0]  a_r;
  logic signed [BH_W-1:0] bh_r;
  logic signed [S_W-1:0]  sum, shf;
  logic signed [WORD_W-1:0] res_r;

  // split the value at bit 16 to keep each multiplier narrow
  assign vh      = VH_W'(val >>> 16);
  assign a_prod  = vh * cos_q;
  assign bl_prod = $signed({1'b0, val[15:0]}) * cos_q;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_prod;
      bh_r <= BH_W'(bl_prod >>> 16);
    end
  end

  // recombine, floor to Q.16 and saturate
  assign sum = S_W'(a_r) + S_W'(bh_r);
  assign shf = sum >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      if (shf > SAT_HI) begin
        res_r <= WORD_W'(SAT_HI);
      end else if (shf < SAT_LO) begin
        res_r <= WORD_W'(SAT_LO);
      end else begin
        res_r <= WORD_W'(shf);
      end
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== sv/plane_wave_field_eval.sv =====
`default_nettype none
// Plane wave field evaluator. For each word (pos_x, pos_y, pos_z, time_now)
// it returns E = amp * cos(r.k - omega*t) and B = (k x amp) * cos(...), all
// signed Q16.16 and saturated. One word is taken per clock while in_stall is
// low. Stages in order: products and sum, modulo-2*pi reduction by reciprocal
// multiply and one compare and subtract, angle fold, one CORDIC rotation per
// stage, sign, and the split multiply/saturate. An output skid register holds
// one result while out_stall is high; in_stall rises only when that register
// is occupied. Registers are written through cfg_we/cfg_index/cfg_data by the
// user only while idle; the block itself does not enforce this.
module plane_wave_field_eval #(
  parameter int CORDIC_STEPS = pwf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic        [pwf_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic        [pwf_pkg::WORD_W-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  in_pos_x,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  in_pos_y,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  in_pos_z,
  input  wire logic signed [pwf_pkg::WORD_W-1:0]  in_time_now,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_e_x,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_e_y,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_e_z,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_b_x,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_b_y,
  output logic signed      [pwf_pkg::WORD_W-1:0]  out_b_z
);
  import pwf_pkg::*;

  localparam int LANES = 6;

  logic signed [WORD_W-1:0] k_x_r, k_y_r, k_z_r, amp_x_r, amp_y_r, amp_z_r;
  logic        [FREQ_W-1:0] freq_r;

  logic signed [2*WORD_W-1:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  logic signed [PROD_W-1:0]   c_yz_r, c_zy_r, c_zx_r, c_xz_r, c_xy_r, c_yx_r;
  logic signed [CROSS_W-1:0]  cx_r, cy_r, cz_r;

  logic                     en;
  logic                     ph_v, cq_v;
  logic [PH_W-1:0]          ph;
  logic signed [CW-1:0]     cq;
  logic [1:0]               sv_r;
  logic signed [CROSS_W-1:0] lane_val [LANES];
  logic signed [WORD_W-1:0]  lane_res [LANES];
  logic signed [WORD_W-1:0]  skid_r   [LANES];
  logic                     skid_full_r, skid_full_nxt;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_x_r   <= '0;
      k_y_r   <= '0;
      k_z_r   <= '0;
      freq_r  <= '0;
      amp_x_r <= '0;
      amp_y_r <= '0;
      amp_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_K_X:   k_x_r   <= cfg_data;
        REG_K_Y:   k_y_r   <= cfg_data;
        REG_K_Z:   k_z_r   <= cfg_data;
        REG_FREQ:  freq_r  <= cfg_data[FREQ_W-1:0];
        REG_AMP_X: amp_x_r <= cfg_data;
        REG_AMP_Y: amp_y_r <= cfg_data;
        REG_AMP_Z: amp_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // k x amp, recomputed every cycle from the settled registers
  assign m_yz = k_y_r * amp_z_r;
  assign m_zy = k_z_r * amp_y_r;
  assign m_zx = k_z_r * amp_x_r;
  assign m_xz = k_x_r * amp_z_r;
  assign m_xy = k_x_r * amp_y_r;
  assign m_yx = k_y_r * amp_x_r;

  always_ff @(posedge clk) begin
    c_yz_r <= PROD_W'(m_yz >>> 16);
    c_zy_r <= PROD_W'(m_zy >>> 16);
    c_zx_r <= PROD_W'(m_zx >>> 16);
    c_xz_r <= PROD_W'(m_xz >>> 16);
    c_xy_r <= PROD_W'(m_xy >>> 16);
    c_yx_r <= PROD_W'(m_yx >>> 16);
    cx_r   <= CROSS_W'(c_yz_r) - CROSS_W'(c_zy_r);
    cy_r   <= CROSS_W'(c_zx_r) - CROSS_W'(c_xz_r);
    cz_r   <= CROSS_W'(c_xy_r) - CROSS_W'(c_yx_r);
  end

  // the whole pipeline advances while the skid register is free
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  pwf_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .t_now (in_time_now),
    .k_x   (k_x_r),
    .k_y   (k_y_r),
    .k_z   (k_z_r),
    .freq  (freq_r),
    .out_v (ph_v),
    .phase (ph)
  );

  pwf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (ph_v),
    .phase (ph),
    .out_v (cq_v),
    .cos_q (cq)
  );

  assign lane_val[0] = CROSS_W'(amp_x_r);
  assign lane_val[1] = CROSS_W'(amp_y_r);
  assign lane_val[2] = CROSS_W'(amp_z_r);
  assign lane_val[3] = cx_r;
  assign lane_val[4] = cy_r;
  assign lane_val[5] = cz_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pwf_scale u_scale (
      .clk   (clk),
      .en    (en),
      .val   (lane_val[l]),
      .cos_q (cq),
      .res   (lane_res[l])
    );
  end

  // valid bits alongside the two scale stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= {sv_r[0], cq_v};
    end
  end

  // park the last result when the consumer stalls
  always_comb begin
    skid_full_nxt = skid_full_r;
    if (skid_full_r) begin
      skid_full_nxt = out_stall;
    end else if (sv_r[1] && out_stall) begin
      skid_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
    if (!skid_full_r) begin
      skid_r <= lane_res;
    end
  end

  assign out_valid = skid_full_r | sv_r[1];
  assign out_e_x   = skid_full_r ? skid_r[0] : lane_res[0];
  assign out_e_y   = skid_full_r ? skid_r[1] : lane_res[1];
  assign out_e_z   = skid_full_r ? skid_r[2] : lane_res[2];
  assign out_b_x   = skid_full_r ? skid_r[3] : lane_res[3];
  assign out_b_y   = skid_full_r ? skid_r[4] : lane_res[4];
  assign out_b_z   = skid_full_r ? skid_r[5] : lane_res[5];

endmodule
`default_nettype wire

// ===== sv/pwf_checker.sv =====
`default_nettype none
`include "plane_wave_field_eval_macros.svh"
module pwf_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [pwf_pkg::WORD_W-1:0] out_e_x,
  input wire logic signed [pwf_pkg::WORD_W-1:0] out_b_z
);

  // a stalled word stays offered and unchanged
  `PWF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `PWF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_e_x) && $stable(out_b_z))
  // input back-pressure only while a result is parked
  `PWF_ASSERT_NOW(a_stall_has_word, in_stall, out_valid)
  `PWF_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind plane_wave_field_eval pwf_checker u_pwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_e_x   (out_e_x),
  .out_b_z   (out_b_z)
);
`default_nettype wire
